[hw/rtl/packed_pixel_store_assert.svh]
// Assertion macros shared by the packed pixel store modules.
`ifndef PACKED_PIXEL_STORE_ASSERT_SVH
`define PACKED_PIXEL_STORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/pps_pkg.sv]
`default_nettype none

package pps_pkg;

    localparam int PPS_MAX_WIDTH  = 256;
    localparam int PPS_MAX_HEIGHT = 256;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int COORD_W    = 16;
    localparam int PIX_W      = 8;
    localparam int DEPTH_W    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_DEPTH  = 2'd2
    } t_cfg_idx;

    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic prep;
        logic calc_addr;
        logic mem_read;
        logic mem_modify;
        logic load_out;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic in_range;
    } t_status;

endpackage

`default_nettype wire

[hw/rtl/pps_ctrl.sv]
`default_nettype none

`include "packed_pixel_store_assert.svh"

module pps_ctrl
    import pps_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    output logic         o_s_tready,
    output logic         o_m_tvalid,
    input  wire logic    i_m_tready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_ADDR,
        S_READ,
        S_MODIFY,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    t_cmd   cmd;

    always_comb begin
        cmd         = '0;
        n_state     = r_state;
        case (r_state)
            S_IDLE: begin
                cmd.load_item = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                cmd.prep = 1'b1;
                n_state  = S_ADDR;
            end
            S_ADDR: begin
                cmd.calc_addr = 1'b1;
                // skip the memory entirely for coordinates outside the image
                n_state = i_status.in_range ? S_READ : S_DONE;
            end
            S_READ: begin
                cmd.mem_read = 1'b1;
                n_state      = S_MODIFY;
            end
            S_MODIFY: begin
                cmd.mem_modify = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                cmd.load_out = !r_out_valid || i_m_tready;
                if (cmd.load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_cmd      = cmd;

    `PPS_ASSERT_NOW(a_load_out_free, i_clk, i_rst_n, cmd.load_out,
        !r_out_valid || i_m_tready, "result loaded over an unsent result")
    `PPS_ASSERT_NOW(a_read_in_range, i_clk, i_rst_n, cmd.mem_read || cmd.mem_modify,
        i_status.in_range, "memory access for coordinates outside the image")
    `PPS_ASSERT_NEXT(a_valid_from_done, i_clk, i_rst_n,
        (r_state != S_DONE) && !r_out_valid, !r_out_valid,
        "result valid raised outside the done step")

endmodule

`default_nettype wire

[hw/rtl/pps_dpath.sv]
`default_nettype none

`include "packed_pixel_store_assert.svh"

module pps_dpath
    import pps_pkg::*;
#(
    parameter int MAX_WIDTH  = PPS_MAX_WIDTH,
    parameter int MAX_HEIGHT = PPS_MAX_HEIGHT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire t_cmd                  i_cmd,
    output t_status                    o_status,
    input  wire logic                  i_action,
    input  wire logic [COORD_W-1:0]    i_x_coord,
    input  wire logic [COORD_W-1:0]    i_y_coord,
    input  wire logic [COORD_W-1:0]    i_color,
    output logic [PIX_W-1:0]           o_pixel_value,
    output logic                       o_ok
);

    localparam int ROW_BYTES_MAX = ((MAX_WIDTH + 3) / 4) * 4;
    localparam int STORE_BYTES   = ROW_BYTES_MAX * MAX_HEIGHT;
    localparam int AW            = $clog2(STORE_BYTES);
    localparam int SUM_W         = 20;

    // configuration
    logic [CFG_DATA_W-1:0] r_width;
    logic [CFG_DATA_W-1:0] r_height;
    logic [DEPTH_W-1:0]    r_depth;

    // accepted request
    logic                  r_write;
    logic [COORD_W-1:0]    r_x;
    logic [COORD_W-1:0]    r_y;
    logic [COORD_W-1:0]    r_color;

    // prepared geometry
    logic                  r_in_range;
    logic [8:0]            r_y9;
    logic [9:0]            r_stride;
    logic [8:0]            r_offset;
    logic [2:0]            r_shift;
    logic [PIX_W-1:0]      r_mask;
    logic [PIX_W-1:0]      r_value;

    logic [AW-1:0]         r_addr;
    logic [PIX_W-1:0]      r_rd_data;
    logic [PIX_W-1:0]      r_pix;
    logic [PIX_W-1:0]      r_out_pixel;
    logic                  r_out_ok;

    logic [PIX_W-1:0]      r_mem [STORE_BYTES];

    logic [CFG_DATA_W-1:0] w_eff;
    logic [CFG_DATA_W-1:0] h_eff;
    logic [3:0]            bpp;
    logic [PIX_W-1:0]      mask;
    logic [11:0]           row_bits;
    logic [12:0]           row_round;
    logic [11:0]           x_bits;
    logic [3:0]            shift_full;
    logic                  x_ok;
    logic                  y_ok;
    logic [PIX_W-1:0]      clamped;
    logic [18:0]           row_base;
    logic [SUM_W-1:0]      addr_full;
    logic [PIX_W-1:0]      place_mask;
    logic [PIX_W-1:0]      merged;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= '0;
            r_height <= '0;
            r_depth  <= DEPTH_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                CFG_DEPTH:  r_depth  <= i_cfg_data[DEPTH_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        w_eff = (32'(r_width) > MAX_WIDTH) ? CFG_DATA_W'(MAX_WIDTH) : r_width;
        h_eff = (32'(r_height) > MAX_HEIGHT) ? CFG_DATA_W'(MAX_HEIGHT) : r_height;
        bpp   = 4'd1 << r_depth;
        mask  = PIX_W'((9'd1 << bpp) - 9'd1);

        // stride in bytes, rounded up to whole 32-bit words
        row_bits  = 12'(w_eff) << r_depth;
        row_round = 13'(row_bits) + 13'd31;

        x_bits     = 12'(r_x[8:0]) << r_depth;
        shift_full = 4'd8 - 4'(x_bits[2:0]) - bpp;

        x_ok = !r_x[COORD_W-1] && (r_x[COORD_W-2:0] < 15'(w_eff));
        y_ok = !r_y[COORD_W-1] && (r_y[COORD_W-2:0] < 15'(h_eff));

        // saturate the color into the pixel range
        if (r_color[COORD_W-1]) begin
            clamped = '0;
        end else if (r_color[COORD_W-2:0] > 15'(mask)) begin
            clamped = mask;
        end else begin
            clamped = r_color[PIX_W-1:0];
        end

        row_base  = 19'(r_y9) * 19'(r_stride);
        addr_full = SUM_W'(row_base) + SUM_W'(r_offset);

        place_mask = PIX_W'(r_mask << r_shift);
        merged     = (r_rd_data & ~place_mask) | PIX_W'(r_value << r_shift);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_write <= i_action;
            r_x     <= i_x_coord;
            r_y     <= i_y_coord;
            r_color <= i_color;
        end
        if (i_cmd.prep) begin
            r_in_range <= x_ok && y_ok;
            r_y9       <= r_y[8:0];
            r_stride   <= {row_round[12:5], 2'b00};
            r_offset   <= x_bits[11:3];
            r_shift    <= shift_full[2:0];
            r_mask     <= mask;
            r_value    <= clamped;
        end
        if (i_cmd.calc_addr) begin
            r_addr <= AW'(addr_full);
        end
        if (i_cmd.mem_modify) begin
            r_pix <= (r_rd_data >> r_shift) & r_mask;
        end
        if (i_cmd.load_out) begin
            r_out_ok    <= r_in_range;
            r_out_pixel <= (r_in_range && !r_write) ? r_pix : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_read) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_modify && r_write) begin
            r_mem[r_addr] <= merged;
        end
    end

    assign o_status.in_range = r_in_range;
    assign o_pixel_value     = r_out_pixel;
    assign o_ok              = r_out_ok;

    `PPS_ASSERT_NEXT(a_outside_zero, i_clk, i_rst_n, i_cmd.load_out && !r_in_range,
        (r_out_pixel == '0) && !r_out_ok, "outside request gave nonzero result")
    `PPS_ASSERT_NEXT(a_write_zero, i_clk, i_rst_n, i_cmd.load_out && r_write,
        r_out_pixel == '0, "write request returned a pixel value")

endmodule

`default_nettype wire

[hw/rtl/packed_pixel_store.sv]
`default_nettype none

// Packed pixel frame store. Each request on the input stream reads or writes
// one pixel at signed (x, y); pixels are packed at 1, 2, 4 or 8 bits, most
// significant first in each byte, and every row starts on a 4-byte boundary.
// Coordinates outside the configured width and height return ok low with a
// zero pixel and leave the store untouched; writes saturate the color to the
// pixel range and return a zero pixel. One request is in flight at a time:
// an in-range request reaches the output register after the controller
// steps through preparation, address calculation and a read-modify-write
// on the single-port byte memory; an outside request skips the memory
// steps. The next request is accepted the cycle after the result is loaded,
// so a request is never taken before the last one is through.
// A result waiting in the output register does not block acceptance of the
// next request, but that request holds in its final step until the waiting
// result is taken.
// The store powers up with undefined contents; read only what was written.
// Configuration writes are taken every cycle and must arrive only when idle.
module packed_pixel_store
    import pps_pkg::*;
#(
    parameter int MAX_WIDTH  = PPS_MAX_WIDTH,
    parameter int MAX_HEIGHT = PPS_MAX_HEIGHT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [47:0]           s_axis_tdata,   // x_coord, y_coord, color
    input  wire logic                  s_axis_tuser,   // action
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [7:0]                 m_axis_tdata,   // pixel_value
    output logic                       m_axis_tuser    // ok
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    pps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pps_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_action      (s_axis_tuser),
        .i_x_coord     (s_axis_tdata[15:0]),
        .i_y_coord     (s_axis_tdata[31:16]),
        .i_color       (s_axis_tdata[47:32]),
        .o_pixel_value (m_axis_tdata),
        .o_ok          (m_axis_tuser)
    );

endmodule

`default_nettype wire

[tb/tb_packed_pixel_store.sv]
`default_nettype none

module tb_packed_pixel_store
    import pps_pkg::*;
();

    typedef struct {
        logic [7:0] pixel;
        logic       ok;
    } t_pixel_result;

    // Scoreboard: keeps its own copy of the frame and geometry, predicts one
    // result per accepted request and checks results in order.
    class frame_scoreboard;
        bit [7:0]      frame_bytes [65536];
        bit [7:0]      known_bits  [65536];
        int unsigned   cfg_width;
        int unsigned   cfg_height;
        int unsigned   cfg_depth;
        t_pixel_result expected_results [$];
        int            mismatches;
        int            checked;

        function new();
            cfg_width  = 0;
            cfg_height = 0;
            cfg_depth  = 32'(DEPTH_RESET);
            mismatches = 0;
            checked    = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_WIDTH:  cfg_width  = 32'(data);
                CFG_HEIGHT: cfg_height = 32'(data);
                CFG_DEPTH:  cfg_depth  = 32'(data[DEPTH_W-1:0]);
                default: ;
            endcase
        endfunction

        function int unsigned span_x();
            return (cfg_width > PPS_MAX_WIDTH) ? PPS_MAX_WIDTH : cfg_width;
        endfunction

        function int unsigned span_y();
            return (cfg_height > PPS_MAX_HEIGHT) ? PPS_MAX_HEIGHT : cfg_height;
        endfunction

        function int unsigned pixel_mask();
            return (1 << (1 << cfg_depth)) - 1;
        endfunction

        function bit inside_image(int x, int y);
            return x >= 0 && y >= 0 && x < int'(span_x()) && y < int'(span_y());
        endfunction

        // Byte address and bit shift of pixel (x, y) under the current packing.
        function void place(int x, int y, output int unsigned addr,
                            output int unsigned shift);
            int unsigned bpp;
            int unsigned stride;
            int unsigned bitpos;
            bpp    = 1 << cfg_depth;
            stride = 4 * ((span_x() * bpp + 31) / 32);
            bitpos = x * bpp;
            shift  = 8 - (bitpos % 8) - bpp;
            addr   = (y * stride + bitpos / 8) % 65536;
        endfunction

        // True unless the request would read pixel bits never written.
        function bit readable(int x, int y);
            int unsigned addr;
            int unsigned shift;
            if (!inside_image(x, y))
                return 1'b1;
            place(x, y, addr, shift);
            return ((known_bits[addr] >> shift) & pixel_mask()) == pixel_mask();
        endfunction

        function void note_request(bit act, logic signed [15:0] x,
                                   logic signed [15:0] y, logic signed [15:0] c);
            t_pixel_result r;
            int            ci;
            int unsigned   addr;
            int unsigned   shift;
            int unsigned   mask;
            int unsigned   v;
            r.pixel = '0;
            r.ok    = 1'b0;
            ci      = int'(c);
            if (inside_image(int'(x), int'(y))) begin
                place(int'(x), int'(y), addr, shift);
                mask = pixel_mask();
                r.ok = 1'b1;
                if (!act) begin
                    r.pixel = 8'((frame_bytes[addr] >> shift) & mask);
                end else begin
                    // saturate the color to the pixel range
                    if (ci < 0)
                        v = 0;
                    else if (ci > int'(mask))
                        v = mask;
                    else
                        v = ci;
                    frame_bytes[addr] = 8'((frame_bytes[addr] & ~(mask << shift))
                                           | (v << shift));
                    known_bits[addr]  = 8'(known_bits[addr] | (mask << shift));
                end
            end
            expected_results.push_back(r);
        endfunction

        function void check_result(logic [7:0] pixel, logic ok);
            t_pixel_result e;
            checked++;
            if (expected_results.size() == 0) begin
                if (mismatches < 10)
                    $display("ERROR: result pixel %0d ok %0b arrived with none pending",
                             pixel, ok);
                mismatches++;
                return;
            end
            e = expected_results.pop_front();
            if (pixel !== e.pixel || ok !== e.ok) begin
                if (mismatches < 10)
                    $display("ERROR: result %0d expected pixel %0d ok %0b, got pixel %0d ok %0b",
                             checked, e.pixel, e.ok, pixel, ok);
                mismatches++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    t_cfg_idx              i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [47:0]           s_axis_tdata;   // x_coord, y_coord, color
    logic                  s_axis_tuser;   // action
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [7:0]            m_axis_tdata;   // pixel_value
    logic                  m_axis_tuser;   // ok

    frame_scoreboard board = new();

    int          geo_w [9] = '{511, 16, 13, 7, 0, 256, 40, 24, 9};
    int          geo_h [9] = '{511, 8, 4, 9, 0, 1, 300, 6, 3};
    int          geo_d [9] = '{3, 0, 1, 2, 3, 0, 2, 3, 1};
    int          geo_n [9] = '{200, 250, 250, 250, 60, 250, 200, 250, 200};
    logic [31:0] written_spots [$];
    bit          sender_calm;
    int          requests_sent;
    int          hold_left;
    bit          held;

    packed_pixel_store i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #5000000;
        $display("ERROR: run timed out");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tuser);
    end

    // Result side: random stalls, one long hold-off, then a stall-free stretch.
    initial begin
        m_axis_tready = 1'b0;
        hold_left     = 0;
        held          = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_left != 0) begin
                m_axis_tready = 1'b0;
                hold_left--;
            end else if (!held && board.checked >= 300) begin
                held          = 1'b1;
                hold_left     = 250;
                m_axis_tready = 1'b0;
            end else if (board.checked >= 1000 && board.checked < 1300) begin
                m_axis_tready = 1'b1;
            end else begin
                m_axis_tready = ($urandom_range(0, 99) >= 21);
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    task automatic set_geometry(int w, int h, int d);
        write_reg(CFG_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_DEPTH, CFG_DATA_W'(d));
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        written_spots.delete();
    endtask

    task automatic send_request(bit act, logic signed [15:0] x, logic signed [15:0] y,
                                logic signed [15:0] c);
        @(negedge i_clk);
        while (!sender_calm && $urandom_range(0, 99) < 21) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {c, y, x};
        s_axis_tuser  = act;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_request(act, x, y, c);
        requests_sent++;
    endtask

    // Turn a read of unwritten pixel bits into a write; remember written pixels.
    task automatic issue_request(bit act, logic signed [15:0] x, logic signed [15:0] y,
                                 logic signed [15:0] c);
        if (!act && !board.readable(int'(x), int'(y)))
            act = 1'b1;
        if (act && board.inside_image(int'(x), int'(y)))
            written_spots.push_back({y, x});
        send_request(act, x, y, c);
    endtask

    task automatic random_request();
        int unsigned        sel;
        int unsigned        w;
        int unsigned        h;
        int unsigned        mask;
        logic [31:0]        spot;
        bit                 act;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] c;
        w    = board.span_x();
        h    = board.span_y();
        mask = board.pixel_mask();
        sel  = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: c = 16'($urandom);
            1: c = 16'($urandom_range(0, mask + 2));
            2: c = -16'($urandom_range(1, 4));
            default: c = 16'($urandom_range(0, 255));
        endcase
        if (sel < 15 || w == 0 || h == 0) begin
            act = 1'($urandom_range(0, 1));
            x   = 16'($urandom);
            y   = 16'($urandom);
            case ($urandom_range(0, 4))
                0: x = 16'(w);
                1: y = 16'(h);
                2: x = -16'sd1;
                3: y = -16'sd1;
                default: ;
            endcase
        end else begin
            x   = 16'($urandom_range(0, w - 1));
            y   = 16'($urandom_range(0, h - 1));
            act = (sel < 57);
            if (!act && !board.readable(int'(x), int'(y)) && written_spots.size() != 0) begin
                spot = written_spots[$urandom_range(0, written_spots.size() - 1)];
                x    = spot[15:0];
                y    = spot[31:16];
            end
        end
        issue_request(act, x, y, c);
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (board.expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    initial begin
        int failures;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_WIDTH;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        sender_calm   = 1'b0;
        requests_sent = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int p = 0; p < 9; p++) begin
            set_geometry(geo_w[p], geo_h[p], geo_d[p]);
            sender_calm = (p == 5);
            if (p == 0) begin
                // oversized width and height clip to the maximum image
                issue_request(1'b1, 16'sd0, 16'sd0, 16'sh7fff);
                issue_request(1'b0, 16'sd0, 16'sd0, 16'sd0);
                issue_request(1'b1, 16'sd255, 16'sd255, -16'sh8000);
                issue_request(1'b0, 16'sd255, 16'sd255, 16'sh7fff);
                issue_request(1'b1, 16'sd255, 16'sd0, 16'sd200);
                issue_request(1'b0, 16'sd255, 16'sd0, 16'sd0);
                issue_request(1'b1, 16'sd0, 16'sd255, 16'sd256);
                issue_request(1'b0, 16'sd0, 16'sd255, 16'sd0);
                issue_request(1'b1, 16'sd1, 16'sd0, 16'sd0);
                issue_request(1'b0, 16'sd1, 16'sd0, 16'sd0);
                issue_request(1'b0, 16'sd256, 16'sd0, 16'sd0);
                issue_request(1'b1, 16'sd0, 16'sd256, 16'sd5);
                issue_request(1'b0, -16'sd1, 16'sd0, 16'sd0);
                issue_request(1'b1, 16'sd0, -16'sd1, 16'sd7);
                issue_request(1'b0, -16'sh8000, -16'sh8000, -16'sd1);
                issue_request(1'b1, 16'sh7fff, 16'sh7fff, 16'sd1);
                issue_request(1'b0, 16'sh7fff, 16'sd0, 16'sd0);
            end
            for (int n = 0; n < geo_n[p]; n++) begin
                // let every pending result drain once mid-phase
                if (p == 2 && n == 120) begin
                    @(negedge i_clk);
                    s_axis_tvalid = 1'b0;
                    while (board.expected_results.size() != 0) @(posedge i_clk);
                end
                random_request();
            end
            drain();
        end

        failures = board.mismatches + board.expected_results.size();
        if (board.expected_results.size() != 0)
            $display("ERROR: %0d expected results never arrived",
                     board.expected_results.size());
        $display("Ran %0d pixel reads and writes over 9 geometries (1 to 8 bits per pixel,",
                 requests_sent);
        $display("  empty, single-row and oversized images); %0d results compared.",
                 board.checked);
        if (failures == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
+incdir+hw/rtl
hw/rtl/pps_pkg.sv
hw/rtl/pps_ctrl.sv
hw/rtl/pps_dpath.sv
hw/rtl/packed_pixel_store.sv
tb/tb_packed_pixel_store.sv
